// ===== hdl/lfu_pkg.sv =====
// Package: constants, types and request codes for the LFU cache table.
package lfu_pkg;
  localparam int Entries = 16;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = IdxW + 1;
  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int UseW = 16;
  localparam logic [UseW-1:0] UseMax = '1;

  typedef enum logic [2:0] {
    REQ_GET = 3'd0, REQ_PUT = 3'd1, REQ_CONTAINS = 3'd2,
    REQ_REMOVE = 3'd3, REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_FIX, ST_OUT
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic [UseW-1:0] use_cnt;
    logic [IdxW-1:0] rank;
  } slot_t;
endpackage

// ===== hdl/lfu_slot_ram.sv =====
// Slot memory: one write port, one registered read port.
module lfu_slot_ram import lfu_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  slot_t           wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output slot_t           rdata_o
);
  slot_t mem [Entries];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/lfu_cache_table.sv =====
// Top level: LFU cache table with LRU tie-break over a slot memory.
// Flow: scan the slot memory, decide, then a second scan fixes ranks and use counts
// for a hit on get or put, an eviction or a remove; then the result is valid.
// Requests: a new one is taken only once the result of the last has been accepted.
// Reset: asynchronous active low; valid bits and occupancy cleared, capacity set to 16 at once.
module lfu_cache_table import lfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // req_type[2:0], key[34:3], write_value[66:35]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // hit, read_value, evicted_valid, evicted_key, occ
);
  state_e state_q, state_d;
  logic [4:0] cap_q;
  logic [Entries-1:0] valid_q, valid_d;
  logic [CntW-1:0] live_q, live_d;
  logic [2:0] req_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] wv_q;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic rvld_q;
  logic [IdxW-1:0] ridx_q;
  logic hit_q, hit_d, vic_ok_q, vic_ok_d, free_ok_q, free_ok_d;
  logic [IdxW-1:0] hidx_q, hidx_d, vidx_q, vidx_d, fidx_q, fidx_d;
  slot_t hslot_q, hslot_d, vslot_q, vslot_d;
  // rank fix pass: ranks above gap_q drop by one; tgt_q gets newr_q
  logic fix_gap_q, fix_gap_d;
  logic [IdxW-1:0] gap_q, gap_d, tgt_q, tgt_d, newr_q, newr_d;
  logic [Entries-1:0] excl_q, excl_d;
  logic [71:0] out_q, out_d;
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t wdata, rdata;
  logic [CntW-1:0] cap_eff;

  lfu_slot_ram u_ram (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata));

  assign cap_eff = (cap_q == 5'd0) ? CntW'(1) :
                   (cap_q > 5'(Entries)) ? CntW'(Entries) : CntW'(cap_q);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o = out_q;
  assign raddr = ptr_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q <= 5'd16;
      valid_q <= '0;
      live_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      live_q <= live_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      rvld_q <= (state_q == ST_SCAN || state_q == ST_FIX) && ptr_q < CntW'(Entries);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      req_q <= s_axis_tdata_i[2:0];
      key_q <= s_axis_tdata_i[34:3];
      wv_q <= s_axis_tdata_i[66:35];
    end
    ridx_q <= ptr_q[IdxW-1:0];
    ptr_q <= ptr_d; hit_q <= hit_d; vic_ok_q <= vic_ok_d; free_ok_q <= free_ok_d;
    hidx_q <= hidx_d; vidx_q <= vidx_d; fidx_q <= fidx_d;
    hslot_q <= hslot_d; vslot_q <= vslot_d;
    fix_gap_q <= fix_gap_d; gap_q <= gap_d; tgt_q <= tgt_d; newr_q <= newr_d;
    excl_q <= excl_d; out_q <= out_d;
  end

  always_comb begin
    state_d = state_q; valid_d = valid_q; live_d = live_q; ptr_d = ptr_q;
    hit_d = hit_q; vic_ok_d = vic_ok_q; free_ok_d = free_ok_q;
    hidx_d = hidx_q; vidx_d = vidx_q; fidx_d = fidx_q;
    hslot_d = hslot_q; vslot_d = vslot_q; fix_gap_d = fix_gap_q;
    gap_d = gap_q; tgt_d = tgt_q; newr_d = newr_q; excl_d = excl_q; out_d = out_q;
    we = 1'b0; waddr = '0; wdata = rdata;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_SCAN; ptr_d = '0; hit_d = 1'b0; vic_ok_d = 1'b0; free_ok_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (ptr_q < CntW'(Entries)) ptr_d = ptr_q + 1'b1;
        if (rvld_q) begin
          if (valid_q[ridx_q]) begin
            if (rdata.key == key_q && !hit_q) begin
              hit_d = 1'b1; hidx_d = ridx_q; hslot_d = rdata;
            end
            if (!vic_ok_q || rdata.use_cnt < vslot_q.use_cnt ||
                (rdata.use_cnt == vslot_q.use_cnt && rdata.rank < vslot_q.rank)) begin
              vic_ok_d = 1'b1; vidx_d = ridx_q; vslot_d = rdata;
            end
          end else if (!free_ok_q) begin
            free_ok_d = 1'b1; fidx_d = ridx_q;
          end
        end else if (ptr_q == CntW'(Entries)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        out_d = '0;
        fix_gap_d = 1'b0; excl_d = '0; ptr_d = '0;
        tgt_d = hidx_q; newr_d = IdxW'(live_q - 1'b1);
        state_d = ST_OUT;
        case (req_q)
          REQ_GET: if (hit_q) begin
            out_d[0] = 1'b1; out_d[32:1] = hslot_q.value;
            fix_gap_d = 1'b1; gap_d = hslot_q.rank; state_d = ST_FIX;
          end
          REQ_CONTAINS: out_d[0] = hit_q;
          REQ_PUT: begin
            if (hit_q) begin
              out_d[0] = 1'b1;
              fix_gap_d = 1'b1; gap_d = hslot_q.rank; state_d = ST_FIX;
            end else begin
              we = 1'b1; wdata.key = key_q; wdata.value = wv_q; wdata.use_cnt = UseW'(1);
              if (live_q >= cap_eff && vic_ok_q) begin
                out_d[33] = 1'b1; out_d[65:34] = vslot_q.key;
                waddr = vidx_q; wdata.rank = IdxW'(live_q - 1'b1);
                valid_d[vidx_q] = 1'b1;
                excl_d[vidx_q] = 1'b1; fix_gap_d = 1'b1; gap_d = vslot_q.rank;
                state_d = ST_FIX; tgt_d = vidx_q;
                newr_d = IdxW'(live_q - 1'b1);
              end else if (free_ok_q) begin
                waddr = fidx_q; wdata.rank = IdxW'(live_q);
                valid_d[fidx_q] = 1'b1; live_d = live_q + 1'b1;
              end else begin
                we = 1'b0;
              end
            end
          end
          REQ_REMOVE: if (hit_q) begin
            out_d[0] = 1'b1; valid_d[hidx_q] = 1'b0; live_d = live_q - 1'b1;
            fix_gap_d = 1'b1; gap_d = hslot_q.rank; excl_d[hidx_q] = 1'b1;
            state_d = ST_FIX;
          end
          REQ_CLEAR: begin valid_d = '0; live_d = '0; end
          default: ;
        endcase
        out_d[70:66] = 5'(live_d);
      end
      ST_FIX: begin
        if (ptr_q < CntW'(Entries)) ptr_d = ptr_q + 1'b1;
        if (rvld_q) begin
          waddr = ridx_q;
          if (valid_q[ridx_q] && !excl_q[ridx_q]) begin
            if (ridx_q == tgt_q && hit_q && (req_q == REQ_GET || req_q == REQ_PUT)) begin
              we = 1'b1; wdata.rank = newr_q;
              if (rdata.use_cnt != UseMax) wdata.use_cnt = rdata.use_cnt + 1'b1;
              if (req_q == REQ_PUT) wdata.value = wv_q;
            end else if (fix_gap_q && rdata.rank > gap_q) begin
              we = 1'b1; wdata.rank = rdata.rank - 1'b1;
            end
          end
        end else if (ptr_q == CntW'(Entries)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: if (m_axis_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
